// ===== rtl/core/bbsf_pkg.sv =====
// ----------------------------------------------------------------------------
// bbsf_pkg
// Shared constants, command codes and types of the bounded byte stream fifo.
// ----------------------------------------------------------------------------
package bbsf_pkg;

   // ring depth and derived widths
   localparam int DEPTH  = 4096;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CNT_W > 13) ? CNT_W : 13;
   localparam int SUM_W  = CNT_W + 1;

   localparam logic [12:0] CAP_RESET = 13'd4096;

   localparam logic [1:0] CMD_PUSH  = 2'd0;
   localparam logic [1:0] CMD_POP   = 2'd1;
   localparam logic [1:0] CMD_CLOSE = 2'd2;
   localparam logic [1:0] CMD_ERROR = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  data_byte;
      logic [12:0] pop_length;
   } req_payload_type;

   typedef struct packed {
      logic        accepted;
      logic [7:0]  front_byte;
      logic        front_valid;
      logic [12:0] buffered_count;
      logic [12:0] free_space;
      logic [63:0] total_pushed;
      logic [63:0] total_popped;
      logic        is_closed_flag;
      logic        is_finished_flag;
      logic        has_error;
   } rsp_payload_type;

   typedef struct packed {
      logic load_req;
      logic exec;
      logic rd_en;
      logic load_out;
   } ctl_cmd_type;

endpackage

// ===== rtl/core/bbsf_if.sv =====
// ----------------------------------------------------------------------------
// bbsf request and response channels
// Valid/ready channels carrying the request and response payloads.
// ----------------------------------------------------------------------------
interface bbsf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [7:0]  data_byte;
   logic [12:0] pop_length;

   modport source (output valid, output cmd, output data_byte, output pop_length,
                   input ready);
   modport sink (input valid, input cmd, input data_byte, input pop_length,
                 output ready);
endinterface

interface bbsf_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic [7:0]  front_byte;
   logic        front_valid;
   logic [12:0] buffered_count;
   logic [12:0] free_space;
   logic [63:0] total_pushed;
   logic [63:0] total_popped;
   logic        is_closed_flag;
   logic        is_finished_flag;
   logic        has_error;

   modport source (output valid, output accepted, output front_byte, output front_valid,
                   output buffered_count, output free_space, output total_pushed,
                   output total_popped, output is_closed_flag, output is_finished_flag,
                   output has_error, input ready);
   modport sink (input valid, input accepted, input front_byte, input front_valid,
                 input buffered_count, input free_space, input total_pushed,
                 input total_popped, input is_closed_flag, input is_finished_flag,
                 input has_error, output ready);
endinterface

// ===== rtl/core/bbsf_ram.sv =====
// ----------------------------------------------------------------------------
// bbsf_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bbsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/bbsf_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbsf_ctrl
// Sequencer: take a request, update state, read the front, load the response.
// ----------------------------------------------------------------------------
module bbsf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bbsf_pkg::ctl_cmd_type ctl
);
   import bbsf_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_LOAD = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   logic       load;

   always_comb begin
      state_in = state_ff;
      load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: state_in = ST_READ;
         ST_READ: state_in = ST_LOAD;
         ST_LOAD: begin
            // hold until the output register frees up
            if (!out_valid_ff || rsp_ready) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign out_valid_in = load | (out_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = out_valid_ff;
   assign ctl.load_req = req_ready & req_valid;
   assign ctl.exec     = (state_ff == ST_EXEC);
   assign ctl.rd_en    = (state_ff == ST_READ);
   assign ctl.load_out = load;
endmodule

// ===== rtl/core/bbsf_datapath.sv =====
// ----------------------------------------------------------------------------
// bbsf_datapath
// Stream state, ring storage and the response register.
// ----------------------------------------------------------------------------
module bbsf_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [12:0]              csr_write_data,
   input  bbsf_pkg::ctl_cmd_type    ctl,
   input  bbsf_pkg::req_payload_type req_data,
   output bbsf_pkg::rsp_payload_type rsp_data
);
   import bbsf_pkg::*;

   req_payload_type  req_ff;
   rsp_payload_type  out_ff;
   logic [ADDR_W-1:0] rp_ff, rp_in;
   logic [CNT_W-1:0]  held_ff, held_in;
   logic [63:0]       pushed_ff, pushed_in;
   logic [63:0]       popped_ff, popped_in;
   logic              closed_ff, closed_in;
   logic              error_ff, error_in;
   logic [12:0]       cap_ff;
   logic              accepted_ff, accepted_in;

   logic [CMP_W-1:0]  cap_eff;
   logic [CMP_W-1:0]  held_ext;
   logic [CMP_W-1:0]  len_ext;
   logic [CMP_W-1:0]  free_ext;
   logic              push_ok;
   logic              pop_ok;
   logic [CNT_W-1:0]  pop_n;
   logic [SUM_W-1:0]  slot_sum;
   logic [SUM_W-1:0]  rp_sum;
   logic [ADDR_W-1:0] slot;
   logic [7:0]        ram_rd_data;

   // effective capacity saturates at the ring depth
   always_comb begin
      held_ext = CMP_W'(held_ff);
      len_ext  = CMP_W'(req_ff.pop_length);
      if (CMP_W'(cap_ff) > CMP_W'(DEPTH)) begin
         cap_eff = CMP_W'(DEPTH);
      end else begin
         cap_eff = CMP_W'(cap_ff);
      end
      if (held_ext >= cap_eff) begin
         free_ext = '0;
      end else begin
         free_ext = cap_eff - held_ext;
      end
   end

   always_comb begin
      push_ok = (req_ff.cmd == CMD_PUSH) && !error_ff && !closed_ff && (free_ext != '0);
      pop_ok  = (req_ff.cmd == CMD_POP) && !error_ff && (held_ff != '0) &&
                (req_ff.pop_length != '0);
      if (len_ext < held_ext) begin
         pop_n = CNT_W'(len_ext);
      end else begin
         pop_n = held_ff;
      end

      // ring wrap: sums stay below twice the depth
      slot_sum = SUM_W'(rp_ff) + SUM_W'(held_ff);
      if (slot_sum >= SUM_W'(DEPTH)) begin
         slot_sum = slot_sum - SUM_W'(DEPTH);
      end
      slot = slot_sum[ADDR_W-1:0];

      rp_sum = SUM_W'(rp_ff) + SUM_W'(pop_n);
      if (rp_sum >= SUM_W'(DEPTH)) begin
         rp_sum = rp_sum - SUM_W'(DEPTH);
      end
   end

   always_comb begin
      rp_in       = rp_ff;
      held_in     = held_ff;
      pushed_in   = pushed_ff;
      popped_in   = popped_ff;
      closed_in   = closed_ff;
      error_in    = error_ff;
      accepted_in = accepted_ff;
      if (ctl.exec) begin
         accepted_in = 1'b0;
         case (req_ff.cmd)
            CMD_PUSH: begin
               if (push_ok) begin
                  held_in     = held_ff + CNT_W'(1);
                  pushed_in   = pushed_ff + 64'd1;
                  accepted_in = 1'b1;
               end
            end
            CMD_POP: begin
               if (pop_ok) begin
                  rp_in       = rp_sum[ADDR_W-1:0];
                  held_in     = held_ff - pop_n;
                  popped_in   = popped_ff + 64'(pop_n);
                  accepted_in = 1'b1;
               end
            end
            CMD_CLOSE: begin
               closed_in   = 1'b1;
               accepted_in = 1'b1;
            end
            CMD_ERROR: begin
               error_in    = 1'b1;
               accepted_in = 1'b1;
            end
            default: accepted_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff     <= '0;
         held_ff   <= '0;
         pushed_ff <= '0;
         popped_ff <= '0;
         closed_ff <= 1'b0;
         error_ff  <= 1'b0;
         cap_ff    <= CAP_RESET;
      end else begin
         rp_ff     <= rp_in;
         held_ff   <= held_in;
         pushed_ff <= pushed_in;
         popped_ff <= popped_in;
         closed_ff <= closed_in;
         error_ff  <= error_in;
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      accepted_ff <= accepted_in;
      if (ctl.load_req) begin
         req_ff <= req_data;
      end
      if (ctl.load_out) begin
         out_ff.accepted         <= accepted_ff;
         out_ff.front_byte       <= (held_ff != '0) ? ram_rd_data : 8'd0;
         out_ff.front_valid      <= (held_ff != '0);
         out_ff.buffered_count   <= 13'(held_ff);
         out_ff.free_space       <= 13'(free_ext);
         out_ff.total_pushed     <= pushed_ff;
         out_ff.total_popped     <= popped_ff;
         out_ff.is_closed_flag   <= closed_ff;
         out_ff.is_finished_flag <= closed_ff && (held_ff == '0);
         out_ff.has_error        <= error_ff;
      end
   end

   bbsf_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ctl.exec & push_ok),
      .wr_addr (slot),
      .wr_data (req_ff.data_byte),
      .rd_en   (ctl.rd_en),
      .rd_addr (rp_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_data = out_ff;
endmodule

// ===== rtl/core/bounded_byte_stream_fifo.sv =====
// ----------------------------------------------------------------------------
// bounded_byte_stream_fifo
// Bounded byte stream buffer with push, pop, close and error commands.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command (push byte, pop up to pop_length bytes, close,
//   set error); rsp returns one status record per request: accepted, front
//   byte, fill level, free space, 64-bit pushed and popped totals and the
//   closed, finished and error flags.
//   csr_write_enable / csr_write_data load the capacity register; write it
//   only while no request is in flight.
//   A request passes from acceptance to rsp valid through the update of the
//   stream state and ring write, one registered read of the front byte from
//   the ring RAM, then the response register load. No new request is taken
//   until the sequencer has gone through its idle, exec, read and load steps
//   and is back in idle.
//   The next request is accepted while an earlier response still waits in
//   the output register; if the receiver stalls, the following request
//   parks before its load until rsp is taken.
//   Synchronous reset empties the stream, clears totals and flags and sets
//   capacity to 4096; ring contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_byte_stream_fifo (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [12:0] csr_write_data,
   bbsf_req_if.sink    req,
   bbsf_rsp_if.source  rsp
);
   import bbsf_pkg::*;

   ctl_cmd_type     ctl;
   req_payload_type req_data;
   rsp_payload_type rsp_data;

   assign req_data.cmd        = req.cmd;
   assign req_data.data_byte  = req.data_byte;
   assign req_data.pop_length = req.pop_length;

   bbsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .ctl       (ctl)
   );

   bbsf_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .ctl              (ctl),
      .req_data         (req_data),
      .rsp_data         (rsp_data)
   );

   assign rsp.accepted         = rsp_data.accepted;
   assign rsp.front_byte       = rsp_data.front_byte;
   assign rsp.front_valid      = rsp_data.front_valid;
   assign rsp.buffered_count   = rsp_data.buffered_count;
   assign rsp.free_space       = rsp_data.free_space;
   assign rsp.total_pushed     = rsp_data.total_pushed;
   assign rsp.total_popped     = rsp_data.total_popped;
   assign rsp.is_closed_flag   = rsp_data.is_closed_flag;
   assign rsp.is_finished_flag = rsp_data.is_finished_flag;
   assign rsp.has_error        = rsp_data.has_error;
endmodule
